FILE: rtl/lpr_pkg.sv
package lpr_pkg;

    localparam int ADDR_W  = 32;
    localparam int INDEX_W = 4;
    localparam int PORT_W  = 3;

    // Operation codes carried by the op field of an input item.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic               op;
        logic [INDEX_W-1:0] entry_index;
        logic               entry_valid;
        logic [ADDR_W-1:0]  entry_dest;
        logic [ADDR_W-1:0]  entry_mask;
        logic [ADDR_W-1:0]  entry_gateway;
        logic [PORT_W-1:0]  entry_port;
        logic [ADDR_W-1:0]  lookup_addr;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [INDEX_W-1:0] match_index;
        logic [ADDR_W-1:0]  gateway;
        logic [PORT_W-1:0]  out_port;
    } rsp_t;

    // One route as it is kept in the route RAM.
    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } route_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;     // controller can take an item
        logic acc;       // an item is accepted this cycle
        logic step;      // issue the read of the next route
        logic load_out;  // load the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_lookup; // the offered item is a lookup
        logic last;      // the read issued now is the final route
        logic out_free;  // the output register can take a result
    } sts_t;

endpackage

FILE: rtl/lpr_if.sv
interface lpr_req_if import lpr_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lpr_rsp_if import lpr_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/longest_prefix_route_lookup_top.sv
// Longest-prefix route lookup over a table of TABLE_ENTRIES routes.
// The req channel takes one item at a time. A write item (op = write) loads
// destination, mask, gateway and port into one slot and sets or clears its
// valid bit; a slot index beyond the table is ignored. A lookup item scans
// every slot and picks the valid route whose mask is largest among those
// that match the address, the lowest slot winning a tie.
// Every item yields exactly one item on the rsp channel; writes and misses
// return hit = 0 with all other fields zero.
// A lookup passes through an accept step, a scan that issues one read per
// route over the single read port of the route RAM, a drain step that
// compares the last route and a step that loads the output register. A
// write item goes from the accept step straight to the load.
// The result sits in an output register; while the receiver stalls, the
// block still takes the next item and works on it, and waits only when it
// has a second result ready to load.
// Reset clears all valid bits, so the table reads as empty; route contents
// are not cleared and need no clearing pass.
module longest_prefix_route_lookup_top import lpr_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    lpr_req_if.sink    req,
    lpr_rsp_if.source  rsp
);

    cmd_t cmd;
    sts_t sts;

    // The controller sequences accept, scan, drain and result load.
    lpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the route RAM, valid bits, the running best match
    // and the output register.
    lpr_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (req.data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (rsp.valid),
        .out_data  (rsp.data),
        .out_ready (rsp.ready)
    );

    assign req.ready = cmd.ready;

`ifndef SYNTHESIS
    // Once an item is taken, the block is not ready in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("item accepted while previous one still in work");

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp.valid || rsp.ready))
        else $error("output register overwritten");

    // A miss or a write carries all-zero fields.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.data.hit) |-> (rsp.data.match_index == '0
            && rsp.data.gateway == '0 && rsp.data.out_port == '0))
        else $error("nonzero fields on a result without hit");
`endif

endmodule

FILE: rtl/lpr_ram.sv
module lpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lpr_ctrl.sv
module lpr_ctrl import lpr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (in_valid)
                begin
                    cmd.acc    = 1'b1;
                    state_next = sts.is_lookup ? ST_SCAN : ST_RESP;
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The final route read is compared in this cycle.
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/lpr_dp.sv
module lpr_dp import lpr_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  req_t in_data,
    input  cmd_t cmd,
    output sts_t sts,
    output logic out_valid,
    output rsp_t out_data,
    input  logic out_ready
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int RAM_W = $bits(route_t);

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]         cnt_reg;
    logic                     pend_reg;
    logic                     pend_valid_reg;
    logic [IDX_W-1:0]         pend_idx_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic                     found_reg;
    logic [ADDR_W-1:0]        best_mask_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [ADDR_W-1:0]        best_gw_reg;
    logic [PORT_W-1:0]        best_port_reg;
    logic                     out_valid_reg;
    rsp_t                     out_data_reg;
    rsp_t                     out_data_next;

    logic [IDX_W+INDEX_W-1:0] wr_ext;
    logic [IDX_W-1:0]         wr_addr;
    logic                     wr_in_range;
    logic                     wr_en;
    route_t                   wr_route;
    logic [RAM_W-1:0]         rd_word;
    route_t                   rd_route;
    logic                     take;
    logic [IDX_W+INDEX_W-1:0] best_ext;

    // Writes beyond the table are dropped.
    assign wr_ext      = {{IDX_W{1'b0}}, in_data.entry_index};
    assign wr_addr     = wr_ext[IDX_W-1:0];
    assign wr_in_range = (32'(in_data.entry_index) < TABLE_ENTRIES);
    assign wr_en       = cmd.acc && (in_data.op == OP_WRITE) && wr_in_range;

    assign wr_route.dest    = in_data.entry_dest;
    assign wr_route.mask    = in_data.entry_mask;
    assign wr_route.gateway = in_data.entry_gateway;
    assign wr_route.port    = in_data.entry_port;

    lpr_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_route_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_route),
        .raddr (cnt_reg),
        .rdata (rd_word)
    );

    assign rd_route = route_t'(rd_word);

    // A route wins if it matches and its mask is strictly larger, so the
    // lowest index is kept among equal masks.
    assign take = pend_reg && pend_valid_reg
               && (((rd_route.dest ^ addr_reg) & rd_route.mask) == '0)
               && (!found_reg || (rd_route.mask > best_mask_reg));

    assign sts.is_lookup = (in_data.op == OP_LOOKUP);
    assign sts.last      = (cnt_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign best_ext = {{INDEX_W{1'b0}}, best_idx_reg};

    always_comb
    begin
        out_data_next             = '0;
        out_data_next.hit         = found_reg;
        if (found_reg)
        begin
            out_data_next.match_index = best_ext[INDEX_W-1:0];
            out_data_next.gateway     = best_gw_reg;
            out_data_next.out_port    = best_port_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= in_data.entry_valid;
            end

            if (cmd.acc)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            pend_reg <= cmd.step;

            if (cmd.acc)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc)
        begin
            addr_reg <= in_data.lookup_addr;
        end
        if (cmd.step)
        begin
            pend_valid_reg <= valid_reg[cnt_reg];
            pend_idx_reg   <= cnt_reg;
        end
        if (take)
        begin
            best_mask_reg <= rd_route.mask;
            best_idx_reg  <= pend_idx_reg;
            best_gw_reg   <= rd_route.gateway;
            best_port_reg <= rd_route.port;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
